FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside of reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: hw/rtl/lpau_pkg.sv
package lpau_pkg;

    localparam int CHANNELS      = 6;
    localparam int SAMPLE_WIDTH  = 32;

    localparam int COEFF_W       = 17;
    localparam int FRAC_W        = 16;
    localparam int ONE_Q16       = 65536;
    localparam int COEFF_RESET   = ONE_Q16;

    // 2*pi and 1.5*pi in Q16.16; both fit in a 20-bit signed value.
    localparam int TWO_PI_Q16    = 411775;
    localparam int WRAP_LIMIT_Q16 = 308831;
    localparam int CONST_W       = 20;

    localparam int ANGLE_FIRST   = 3;
    localparam int ANGLE_LAST    = 5;

    typedef struct packed {
        logic               accept;
        logic               first;
        logic               wrap;
        logic [COEFF_W-1:0] coeff;
    } lane_ctrl_t;

endpackage

FILE: hw/rtl/six_channel_lowpass_angle_unwrap_top.sv
// An accepted word is registered in the output stage, or in the skid stage while output stalls.
// Throughput: one word per cycle unless the skid stage is full; lanes close their recursion
// (unwrap, one multiply, round, saturate) combinationally, and a skid stage absorbs one stall.
// Reset: coefficient returns to 1.0, every lane's previous output to zero, the filter
// to unprimed, and both output stages to empty.
`include "assert_macros.svh"

module six_channel_lowpass_angle_unwrap_top #(
    parameter  int CHANNELS     = lpau_pkg::CHANNELS,
    parameter  int SAMPLE_WIDTH = lpau_pkg::SAMPLE_WIDTH,
    localparam int TDW          = ((CHANNELS * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lpau_pkg::COEFF_W-1:0] cfg_wdata,   // coeff_b, Q1.16
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // chan0_in, chan1_in, chan2_in, roll_in, pitch_in, yaw_in, then zero padding
    input  logic [TDW-1:0]               s_axis_tdata,
    // wrap_enable
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // chan0_out, chan1_out, chan2_out, roll_out, pitch_out, yaw_out, then zero padding
    output logic [TDW-1:0]               m_axis_tdata
);

    localparam logic [lpau_pkg::COEFF_W-1:0] COEFF_ONE =
        lpau_pkg::COEFF_W'(lpau_pkg::ONE_Q16);

    logic [lpau_pkg::COEFF_W-1:0]         coeff_reg;
    logic                                 primed_reg;
    logic                                 accept;
    logic                                 can_accept;
    lpau_pkg::lane_ctrl_t                 ctrl;
    logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] lane_y;

    assign s_axis_tready = can_accept;
    assign accept        = s_axis_tvalid && can_accept;

    always_comb
    begin
        ctrl.accept = accept;
        ctrl.first  = !primed_reg;
        ctrl.wrap   = s_axis_tuser;
        // Weights above one act as one.
        ctrl.coeff  = (coeff_reg > COEFF_ONE) ? COEFF_ONE : coeff_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg  <= lpau_pkg::COEFF_W'(lpau_pkg::COEFF_RESET);
            primed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                coeff_reg <= cfg_wdata;
            end
            if (accept)
            begin
                primed_reg <= 1'b1;
            end
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        logic signed [SAMPLE_WIDTH-1:0] lane_out;

        lpau_lane #(
            .SW       (SAMPLE_WIDTH),
            .IS_ANGLE ((i >= lpau_pkg::ANGLE_FIRST) && (i <= lpau_pkg::ANGLE_LAST))
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .x     ($signed(s_axis_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
            .y     (lane_out)
        );

        assign lane_y[i] = lane_out;
    end

    lpau_merge #(
        .CH (CHANNELS),
        .SW (SAMPLE_WIDTH)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (accept),
        .lane_y        (lane_y),
        .can_accept    (can_accept),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_CLK(a_primed_after_word, clk, rst_n, accept |=> (primed_reg && m_axis_tvalid))

endmodule

FILE: hw/rtl/lpau_lane.sv
`include "assert_macros.svh"

module lpau_lane #(
    parameter int SW       = lpau_pkg::SAMPLE_WIDTH,
    parameter bit IS_ANGLE = 1'b0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lpau_pkg::lane_ctrl_t   ctrl,
    input  logic signed [SW-1:0]   x,
    output logic signed [SW-1:0]   y
);

    // Working width holds a sample plus a two-pi shift with margin.
    localparam int YW   = ((SW > lpau_pkg::CONST_W) ? SW : lpau_pkg::CONST_W) + 2;
    localparam int DW   = YW + 1;
    localparam int PW   = DW + lpau_pkg::COEFF_W + 1;
    localparam int QW   = PW - lpau_pkg::FRAC_W;
    localparam int SUMW = QW + 1;

    localparam logic signed [YW-1:0] TWO_PI    = YW'(lpau_pkg::TWO_PI_Q16);
    localparam logic signed [YW-1:0] LIMIT_POS = YW'(lpau_pkg::WRAP_LIMIT_Q16);
    localparam logic signed [YW-1:0] LIMIT_NEG = -LIMIT_POS;
    localparam logic signed [PW-1:0] HALF      = PW'(lpau_pkg::ONE_Q16 / 2);
    localparam logic signed [SUMW-1:0] SAT_HI  =
        $signed({{(SUMW-SW+1){1'b0}}, {(SW-1){1'b1}}});
    localparam logic signed [SUMW-1:0] SAT_LO  = ~SAT_HI;

    logic signed [SW-1:0]   prev_reg;
    logic signed [YW-1:0]   x_ext;
    logic signed [YW-1:0]   yp_base;
    logic signed [YW-1:0]   d_base;
    logic signed [YW-1:0]   yp;
    logic signed [DW-1:0]   d;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   rnd;
    logic signed [QW-1:0]   step;
    logic signed [SUMW-1:0] sum;

    always_comb
    begin
        x_ext   = YW'(x);
        yp_base = ctrl.first ? x_ext : YW'(prev_reg);
        d_base  = x_ext - yp_base;
        yp      = yp_base;
        // Angles: pull the previous output one turn toward the new sample.
        if (IS_ANGLE && ctrl.wrap && !ctrl.first)
        begin
            if (d_base > LIMIT_POS)
            begin
                yp = yp_base + TWO_PI;
            end
            else if (d_base < LIMIT_NEG)
            begin
                yp = yp_base - TWO_PI;
            end
        end
        d    = DW'(x_ext) - DW'(yp);
        prod = PW'(d) * PW'($signed({1'b0, ctrl.coeff}));
        rnd  = prod + HALF;
        step = $signed(rnd[PW-1:lpau_pkg::FRAC_W]);
        sum  = SUMW'(yp) + SUMW'(step);
        if (sum > SAT_HI)
        begin
            y = SAT_HI[SW-1:0];
        end
        else if (sum < SAT_LO)
        begin
            y = SAT_LO[SW-1:0];
        end
        else
        begin
            y = sum[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            prev_reg <= y;
        end
    end

    // The first word after reset passes through unchanged.
    `ASSERT_CLK(a_first_passes, clk, rst_n, (ctrl.accept && ctrl.first) |=> prev_reg == $past(x))

endmodule

FILE: hw/rtl/lpau_merge.sv
`include "assert_macros.svh"

module lpau_merge #(
    parameter  int CH  = lpau_pkg::CHANNELS,
    parameter  int SW  = lpau_pkg::SAMPLE_WIDTH,
    localparam int TDW = ((CH * SW + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_accept,
    input  logic [CH-1:0][SW-1:0]    lane_y,
    output logic                     can_accept,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDW-1:0]           m_axis_tdata
);

    logic [TDW-1:0] word_next;
    logic [TDW-1:0] out_data_reg;
    logic [TDW-1:0] skid_data_reg;
    logic           out_valid_reg;
    logic           skid_valid_reg;
    logic           out_fire;
    logic           load_out;
    logic           load_skid;

    // Lane 0 lands in the low bits; padding bits are zero.
    assign word_next = TDW'(lane_y);
    assign out_fire  = out_valid_reg && m_axis_tready;
    assign load_out  = in_accept && (!out_valid_reg || out_fire);
    assign load_skid = in_accept && out_valid_reg && !out_fire;

    assign can_accept    = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (load_skid)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_fire)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (!skid_valid_reg && load_out)
        begin
            out_data_reg <= word_next;
        end
        if (!skid_valid_reg && load_skid)
        begin
            skid_data_reg <= word_next;
        end
    end

    `ASSERT_NEVER(a_skid_alone, clk, rst_n, skid_valid_reg && !out_valid_reg)
    `ASSERT_CLK(a_skid_drains, clk, rst_n, (skid_valid_reg && m_axis_tready) |=> (!skid_valid_reg && out_valid_reg))

endmodule

FILE: verif/tb_six_channel_lowpass_angle_unwrap_top.sv
`timescale 1ns / 1ps

module tb_six_channel_lowpass_angle_unwrap_top;

    import lpau_pkg::*;

    localparam int WORD_W      = ((CHANNELS * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 80;
    localparam int BLOCKS      = 8;
    localparam int BLOCK_ITEMS = 175;
    localparam int DIR_COUNT   = 22;
    localparam int PI_Q16      = TWO_PI_Q16 / 2;

    localparam logic [SAMPLE_WIDTH-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_WIDTH-1:0] S_MIN = 32'h8000_0000;
    localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef logic [0:CHANNELS-1][SAMPLE_WIDTH-1:0] lanes_t;

    // When echo is set, the filter must pass the sample through unchanged
    // (first word after reset, or a weight of 1.0 or above).
    typedef struct packed {
        logic               load_weight;
        logic [COEFF_W-1:0] weight;
        logic               wrap;
        logic               echo;
        lanes_t             smp;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        '{1'b0, 17'd0, 1'b1, 1'b1, '{S_MAX, S_MIN, 32'h0, 32'h000C_9000, 32'hFFFF_FFFF, S_MIN}},
        '{1'b0, 17'd0, 1'b0, 1'b1, '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}},
        '{1'b0, 17'd0, 1'b1, 1'b1, '{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}},
        '{1'b0, 17'd0, 1'b1, 1'b1, '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}},
        '{1'b0, 17'd0, 1'b0, 1'b1, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                     32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}},
        '{1'b0, 17'd0, 1'b1, 1'b1, '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001,
                                     32'h7FF9_E580, 32'h8006_1A80, 32'h0}},
        // Weight zero: the angle lanes shift past the sample range and saturate,
        // and the yaw lane sits exactly on the unwrap threshold.
        '{1'b1, 17'd0, 1'b1, 1'b0, '{S_MAX, S_MIN, 32'h1234_5678, S_MAX, S_MIN, 32'h0004_B65F}},
        '{1'b0, 17'd0, 1'b1, 1'b0, '{32'h0, 32'h0, 32'h0, S_MIN, S_MAX, 32'h0004_B660}},
        '{1'b0, 17'd0, 1'b1, 1'b0, '{32'h0000_FFFF, 32'hFFFF_0001, 32'h0, 32'h0, 32'h0,
                                     32'h0001_921F}},
        '{1'b0, 17'd0, 1'b0, 1'b0, '{S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX}},
        '{1'b1, 17'd32768, 1'b1, 1'b0, '{32'h1, 32'hFFFF_FFFF, 32'h3, 32'h0003_243F,
                                         32'hFFFC_DBC1, 32'h0001_0000}},
        '{1'b0, 17'd0, 1'b1, 1'b0, '{32'hFFFF_FFFF, 32'h1, S_MAX, 32'hFFFC_DBC1,
                                     32'h0003_243F, 32'hFFFF_0000}},
        '{1'b0, 17'd0, 1'b0, 1'b0, '{32'h1, 32'hFFFF_FFFF, 32'h3, 32'h0003_243F,
                                     32'hFFFC_DBC1, 32'h0001_0000}},
        '{1'b0, 17'd0, 1'b1, 1'b0, '{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX}},
        '{1'b1, 17'd65537, 1'b1, 1'b1, '{32'h5, 32'hFFFF_FFFB, 32'h0001_8000, 32'h0004_B660,
                                         32'hFFFB_49A0, 32'h0}},
        '{1'b0, 17'd0, 1'b0, 1'b1, '{S_MAX, 32'h0, S_MIN, 32'h1, 32'hFFFF_FFFF, 32'h8000_0001}},
        '{1'b1, 17'h1_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, S_MIN, S_MAX, 32'h0006_487F,
                                          32'hFFF9_B781, 32'h0000_8000}},
        '{1'b1, 17'd1, 1'b1, 1'b0, '{S_MAX, S_MIN, 32'h1, 32'h0002_0000, 32'hFFFE_0000,
                                     32'h000C_9000}},
        '{1'b0, 17'd0, 1'b1, 1'b0, '{S_MIN, S_MAX, 32'hFFFF_FFFF, 32'hFFFC_DBC1,
                                     32'h0003_243F, 32'hFFF3_7000}},
        '{1'b1, 17'd65535, 1'b1, 1'b0, '{S_MAX, S_MIN, 32'h0, 32'h0003_243F,
                                         32'hFFFC_DBC1, 32'h0}},
        '{1'b0, 17'd0, 1'b0, 1'b0, '{32'h0, 32'h0, S_MAX, 32'hFFFC_DBC1, 32'h0003_243F, S_MIN}},
        '{1'b0, 17'd0, 1'b1, 1'b0, '{32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6}}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [COEFF_W-1:0] cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [WORD_W-1:0]  s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [WORD_W-1:0]  m_axis_tdata;
    logic               s_echo = 1'b0;

    // Filter state as the testbench sees it.
    longint             lane_prev [CHANNELS] = '{default: 0};
    logic               lane_primed = 1'b0;
    logic [COEFF_W-1:0] weight_reg = COEFF_W'(COEFF_RESET);

    lanes_t pending_filtered [$];
    int     fail_count = 0;
    int     src_idle_pct = 0;
    int     sink_stall_pct = 0;
    int     hold_requests = 0;
    int     hold_served = 0;
    int     hold_left = 0;
    string  lane_name [CHANNELS] = '{"chan0", "chan1", "chan2", "roll", "pitch", "yaw"};

    six_channel_lowpass_angle_unwrap_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] lanes_to_word(input lanes_t smp);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            w[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = smp[i];
        end
        return w;
    endfunction

    function automatic lanes_t word_to_lanes(input logic [WORD_W-1:0] w);
        lanes_t smp;
        for (int i = 0; i < CHANNELS; i++)
        begin
            smp[i] = w[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        end
        return smp;
    endfunction

    // One filter update on all lanes; advances the tracked state.
    function automatic lanes_t lowpass_step(input lanes_t smp, input logic wrap);
        lanes_t res;
        longint x, yp, d, dh, dl, b, y;
        b = (weight_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(weight_reg);
        for (int i = 0; i < CHANNELS; i++)
        begin
            x  = longint'(signed'(smp[i]));
            yp = lane_primed ? lane_prev[i] : x;
            if (lane_primed && wrap && i >= ANGLE_FIRST && i <= ANGLE_LAST)
            begin
                d = x - yp;
                if (d > WRAP_LIMIT_Q16)
                    yp = yp + TWO_PI_Q16;
                else if (d < -WRAP_LIMIT_Q16)
                    yp = yp - TWO_PI_Q16;
            end
            // Split the difference so the rounding of the fractional part is
            // done on a non-negative value.
            d  = x - yp;
            dh = d >>> FRAC_W;
            dl = d - dh * ONE_Q16;
            y  = yp + b * dh + (b * dl + ONE_Q16 / 2) / ONE_Q16;
            if (y > SAT_HI)
                y = SAT_HI;
            else if (y < SAT_LO)
                y = SAT_LO;
            lane_prev[i] = y;
            res[i] = y[SAMPLE_WIDTH-1:0];
        end
        lane_primed = 1'b1;
        return res;
    endfunction

    function automatic lanes_t random_lanes();
        lanes_t smp;
        int kind;
        for (int i = 0; i < CHANNELS; i++)
        begin
            kind = $urandom_range(15);
            if (kind == 0)
                smp[i] = $urandom;
            else if (kind == 1)
                smp[i] = $urandom_range(1) ? S_MAX : S_MIN;
            else if (i >= ANGLE_FIRST)
                smp[i] = $urandom_range(2 * PI_Q16) - PI_Q16;
            else
                smp[i] = $urandom_range(1 << 21) - (1 << 20);
        end
        return smp;
    endfunction

    // Checks output words and records the expectation for each accepted input word.
    always @(posedge clk)
    begin
        lanes_t got;
        lanes_t want;
        lanes_t pred;
        if (rst_n)
        begin
            if (cfg_we)
                weight_reg = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = word_to_lanes(m_axis_tdata);
                if (pending_filtered.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("@%0t unexpected output word %h", $time, m_axis_tdata);
                end
                else
                begin
                    want = pending_filtered.pop_front();
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            fail_count++;
                            if (fail_count <= 10)
                                $display("@%0t %s mismatch: expected %h, got %h",
                                         $time, lane_name[i], want[i], got[i]);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred = lowpass_step(word_to_lanes(s_axis_tdata), s_axis_tuser);
                if (s_echo)
                    pending_filtered.push_back(word_to_lanes(s_axis_tdata));
                else
                    pending_filtered.push_back(pred);
            end
        end
    end

    // Output back-pressure, with an occasional long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_word(input lanes_t smp, input logic wrap, input logic echo);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lanes_to_word(smp);
        s_axis_tuser  <= wrap;
        s_echo        <= echo;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_filtered.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_weight(input logic [COEFF_W-1:0] w);
        wait_drained();
        cfg_wdata <= w;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [COEFF_W-1:0] blk_weight [BLOCKS];
        blk_weight[0] = COEFF_W'(ONE_Q16);
        blk_weight[1] = 17'd0;
        blk_weight[2] = 17'd32768;
        blk_weight[3] = 17'd1;
        blk_weight[4] = 17'd65535;
        blk_weight[5] = 17'h1_FFFF;
        blk_weight[6] = COEFF_W'($urandom_range(ONE_Q16));
        blk_weight[7] = COEFF_W'($urandom_range(ONE_Q16 + 1, 17'h1_FFFF));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct   = 8;
        sink_stall_pct = 8;
        for (int r = 0; r < DIR_COUNT; r++)
        begin
            if (DIR_ROWS[r].load_weight)
                write_weight(DIR_ROWS[r].weight);
            send_word(DIR_ROWS[r].smp, DIR_ROWS[r].wrap, DIR_ROWS[r].echo);
        end

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            write_weight(blk_weight[blk]);
            case (blk % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 46;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 46;
                end
                default:
                begin
                    src_idle_pct   = 8;
                    sink_stall_pct = 8;
                end
            endcase
            // The sender keeps streaming through the hold-off so the input stalls.
            if (blk == 0)
                hold_requests++;
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                if (blk == 5 && n == BLOCK_ITEMS / 2)
                    wait_drained();
                send_word(random_lanes(), $urandom_range(3) != 0, 1'b0);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_filtered.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
